// File: hdl/fsubm_pkg.sv
// Shared types and constants for the first substring match block.
// Request payloads, register indexes and size defaults; no dependencies.
`timescale 1ns / 1ps

package fsubm_pkg;

    // Fixed field and register widths
    localparam int BYTE_W       = 8;
    localparam int PAT_BYTES    = 16;
    localparam int PAT_IDX_W    = 4;
    localparam int LEN_W        = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int POS_W        = 16;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEFAULT = 16;
    localparam int TEXT_MAX_DEFAULT    = 65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } reg_index_t;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_bytes_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              has_byte;
        logic              last_item;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             too_long;
    } out_t;

endpackage

// File: hdl/first_substring_match_top.sv
// Top level of the first substring match block: config registers, input
// register, stream state and result register. Depends on fsubm_pkg, fsubm_win_cmp.
`timescale 1ns / 1ps

// Searches a byte stream for a pattern of up to PATTERN_MAX bytes set through
// the config port (pattern_low, pattern_high, pattern_length). One request is
// taken per clock cycle while in_stall is low; it passes the input register
// and the window compare; one with last_item then loads the result register.
// Throughput is one byte per cycle, set by the parallel window compare, while
// output is not stalled. Only a request with last_item yields a result (found,
// 0-based start of the first occurrence, too_long); stream state then clears.
// Write the config registers only while no request is in flight.
module first_substring_match_top #(
    parameter int PATTERN_MAX = fsubm_pkg::PATTERN_MAX_DEFAULT,
    parameter int TEXT_MAX    = fsubm_pkg::TEXT_MAX_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fsubm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fsubm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fsubm_pkg::in_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output fsubm_pkg::out_t                    out_data
);
    import fsubm_pkg::*;

    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Config registers
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      pattern_length_reg;

    // Input register
    logic s1_valid_reg;
    in_t  s1_data_reg;

    // Stream state
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_reg, window_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic                               hit_reg, hit_next;
    logic [POS_W-1:0]                   hit_pos_reg, hit_pos_next;
    logic                               ovf_reg, ovf_next;

    // Result register
    logic out_valid_reg;
    out_t out_data_reg, out_data_next;

    logic             out_free;
    logic             s1_adv;
    logic             in_take;
    logic [LEN_W-1:0] used_len;
    pattern_bytes_t   pattern;
    logic             win_match;
    logic             take_byte;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] start_pos;

    // Handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && (!s1_data_reg.last_item || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the pattern length to the window depth
    assign used_len = (pattern_length_reg > LEN_W'(PATTERN_MAX)) ?
                      LEN_W'(PATTERN_MAX) : pattern_length_reg;
    assign pattern  = {pattern_high_reg, pattern_low_reg};

    // Shift the new byte into the window
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (j == 0)
            begin
                window_next[j] = s1_data_reg.text_byte;
            end
            else
            begin
                window_next[j] = window_reg[j-1];
            end
        end
    end

    fsubm_win_cmp #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_win_cmp (
        .window   (window_next),
        .pattern  (pattern),
        .used_len (used_len),
        .match    (win_match)
    );

    // Update stream state for the request in the input register
    always_comb
    begin
        take_byte = s1_data_reg.has_byte && (count_reg < CNT_W'(TEXT_MAX));
        count_ext = CMP_W'(count_reg) + CMP_W'(1);
        len_ext   = CMP_W'(used_len);
        start_pos = count_ext - len_ext;

        count_next   = count_reg;
        hit_next     = hit_reg;
        hit_pos_next = hit_pos_reg;
        ovf_next     = ovf_reg;

        if (s1_data_reg.has_byte && !take_byte)
        begin
            ovf_next = 1'b1;
        end
        if (take_byte)
        begin
            count_next = count_ext[CNT_W-1:0];
            if (!hit_reg && (used_len != '0) && (count_ext >= len_ext) && win_match)
            begin
                hit_next     = 1'b1;
                hit_pos_next = POS_W'(start_pos);
            end
        end

        out_data_next.too_long = ovf_next;
        if (used_len == '0)
        begin
            out_data_next.found          = 1'b1;
            out_data_next.match_position = '0;
        end
        else
        begin
            out_data_next.found          = hit_next;
            out_data_next.match_position = hit_next ? hit_pos_next : '0;
        end
    end

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Stream state: advance on each request, clear at the end of a text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            hit_pos_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_data_reg.last_item)
            begin
                window_reg  <= '0;
                count_reg   <= '0;
                hit_reg     <= 1'b0;
                hit_pos_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                if (take_byte)
                begin
                    window_reg <= window_next;
                end
                count_reg   <= count_next;
                hit_reg     <= hit_next;
                hit_pos_reg <= hit_pos_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_data_reg.last_item)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_data_reg.last_item)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: hdl/fsubm_win_cmp.sv
// Window compare: checks the newest used_len window bytes against the pattern.
// Depends on fsubm_pkg.
`timescale 1ns / 1ps

module fsubm_win_cmp #(
    parameter int PATTERN_MAX = fsubm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic [PATTERN_MAX-1:0][fsubm_pkg::BYTE_W-1:0] window,
    input  fsubm_pkg::pattern_bytes_t                     pattern,
    input  logic [fsubm_pkg::LEN_W-1:0]                   used_len,
    output logic                                          match
);
    import fsubm_pkg::*;

    // Window slot j (0 = newest) lines up with pattern byte used_len-1-j
    always_comb
    begin
        logic [LEN_W-1:0] diff;
        match = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            diff = used_len - LEN_W'(j) - LEN_W'(1);
            if (LEN_W'(j) < used_len)
            begin
                if (window[j] != pattern[diff[PAT_IDX_W-1:0]])
                begin
                    match = 1'b0;
                end
            end
        end
    end

endmodule

// File: hdl/fsubm_checker.sv
// Port-level checks for first_substring_match_top, attached by bind.
// Depends on fsubm_pkg.
`timescale 1ns / 1ps

module fsubm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input fsubm_pkg::in_t                     in_data,
    input logic                               out_valid,
    input logic                               out_stall,
    input fsubm_pkg::out_t                    out_data
);
    import fsubm_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       last_in;
    logic       res_out;

    // Count end-of-text requests taken but not yet delivered
    assign last_in = in_valid && !in_stall && in_data.last_item;
    assign res_out = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg + 3'(last_in) - 3'(res_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Report no position without a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.match_position == '0)
        else $error("position set on a miss");

    // Push back on input only when the result side is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // Emit results only for end-of-text requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without a matching end-of-text request");

    // Keep at most two end-of-text requests in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("too many end-of-text requests in flight");

endmodule

bind first_substring_match_top fsubm_checker u_fsubm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: tb/testbench.sv
// Testbench for first_substring_match_top: directed table, then random texts
// checked against an in-bench search predictor. Depends on fsubm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import fsubm_pkg::*;

    localparam int TEXT_LIMIT   = TEXT_MAX_DEFAULT;
    localparam int RUN_LIMIT    = 2_000_000;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PCT     = 37;

    typedef enum { ROW_WRITE, ROW_REQ, ROW_FILL } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        reg_index_t            index;
        logic [CFG_DATA_W-1:0] value;
        in_t                   req;
        int                    count;
        bit                    known;
        out_t                  want;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_t                    in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_t                   out_data;

    // Shared run control
    bit          steady         = 1'b0;
    bit          random_started = 1'b0;
    int          hold_left      = HOLD_CYCLES;
    int          errors         = 0;
    int          requests_sent  = 0;
    int unsigned cycle_count    = 0;

    // Search predictor state
    pattern_bytes_t    pat     = '0;
    logic [LEN_W-1:0]  pat_len = '0;
    logic [BYTE_W-1:0] win [PAT_BYTES];
    int unsigned       seen;
    bit                hit;
    bit                ovf;
    logic [POS_W-1:0]  hit_pos;

    out_t      pending_results [$];
    out_t      head;
    stim_row_t plan [$];

    first_substring_match_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Drop the stream state after a text ends
    function automatic void clear_text();
        for (int i = 0; i < PAT_BYTES; i++)
            win[i] = '0;
        seen    = 0;
        hit     = 1'b0;
        ovf     = 1'b0;
        hit_pos = '0;
    endfunction

    // Lengths above the window size use the full window
    function automatic int unsigned live_length();
        return (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
    endfunction

    // Newest byte sits at win[0]; pattern byte 0 lines up with the oldest of n
    function automatic bit window_hit(input int unsigned n);
        for (int k = 0; k < n; k++)
            if (win[n - 1 - k] != pat[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the search by one request; return 1 when it yields a result
    function automatic bit search_step(input in_t req, output out_t res);
        int unsigned n;
        n   = live_length();
        res = '0;
        if (req.has_byte)
        begin
            if (seen >= TEXT_LIMIT)
                ovf = 1'b1;
            else
            begin
                for (int i = PAT_BYTES - 1; i > 0; i--)
                    win[i] = win[i - 1];
                win[0] = req.text_byte;
                seen++;
                if (!hit && n > 0 && seen >= n && window_hit(n))
                begin
                    hit     = 1'b1;
                    hit_pos = POS_W'(seen - n);
                end
            end
        end
        if (!req.last_item)
            return 1'b0;
        res.found          = (n == 0) || hit;
        res.match_position = (n != 0 && hit) ? hit_pos : '0;
        res.too_long       = ovf;
        clear_text();
        return 1'b1;
    endfunction

    // Offer one request, hold it until taken, then predict its result
    task automatic offer_request(input in_t req, input bit known, input out_t want);
        out_t res;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (search_step(req, res))
            pending_results.push_back(known ? want : res);
        if (req.has_byte || req.last_item)
            requests_sent++;
    endtask

    // Stop sending and wait until every result is back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:    pat[7:0]  = value;
            REG_PATTERN_HIGH:   pat[15:8] = value;
            REG_PATTERN_LENGTH: pat_len   = value[LEN_W-1:0];
            default:            ;
        endcase
    endtask

    // Table builders
    task automatic add_write(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.index = idx;
        row.value = value;
        row.req   = '0;
        row.count = 0;
        row.known = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endtask

    task automatic add_req(input logic [7:0] b, input bit has, input bit last,
                           input bit known = 1'b0, input out_t want = '0);
        stim_row_t row;
        row.kind               = ROW_REQ;
        row.index              = REG_PATTERN_LOW;
        row.value              = '0;
        row.count              = 0;
        row.req.text_byte      = b;
        row.req.has_byte       = has;
        row.req.last_item      = last;
        row.known              = known;
        row.want               = want;
        plan.push_back(row);
    endtask

    task automatic add_fill(input int count, input logic [7:0] b);
        stim_row_t row;
        row.kind  = ROW_FILL;
        row.index = REG_PATTERN_LOW;
        row.req   = '0;
        row.known = 1'b0;
        row.want  = '0;
        row.count = count;
        row.value = CFG_DATA_W'(b);
        plan.push_back(row);
    endtask

    // Send one text: pattern copies, partial copies and filler, with stray no-byte requests
    task automatic send_text(input logic [7:0] sym0, input logic [7:0] sym1, input bit narrow);
        logic [7:0]  body [$];
        int unsigned span;
        int unsigned n;
        int unsigned cut;
        bit          close_on_byte;
        in_t         req;
        n             = live_length();
        span          = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
        close_on_byte = $urandom_range(1);
        while (body.size() < span)
        begin
            if (n > 0 && $urandom_range(3) == 0)
            begin
                cut = ($urandom_range(3) == 0) ? $urandom_range(0, n - 1) : n;
                for (int k = 0; k < cut; k++)
                    body.push_back(pat[k]);
            end
            else if (narrow && $urandom_range(4) != 0)
                body.push_back($urandom_range(1) ? sym1 : sym0);
            else
                body.push_back(8'($urandom));
        end
        foreach (body[i])
        begin
            if ($urandom_range(9) == 0)
            begin
                req.text_byte = 8'($urandom);
                req.has_byte  = 1'b0;
                req.last_item = 1'b0;
                offer_request(req, 1'b0, '0);
            end
            req.text_byte = body[i];
            req.has_byte  = 1'b1;
            req.last_item = close_on_byte && (i == body.size() - 1);
            offer_request(req, 1'b0, '0);
        end
        if (body.size() == 0 || !close_on_byte)
        begin
            req.text_byte = 8'($urandom);
            req.has_byte  = 1'b0;
            req.last_item = 1'b1;
            offer_request(req, 1'b0, '0);
        end
    endtask

    // Result checker and receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request pending: %p", out_data);
                    errors++;
                end
                else
                begin
                    head = pending_results.pop_front();
                    if (out_data.found !== head.found)
                    begin
                        $error("found: expected %0d, got %0d", head.found, out_data.found);
                        errors++;
                    end
                    if (out_data.match_position !== head.match_position)
                    begin
                        $error("match_position: expected %0d, got %0d",
                               head.match_position, out_data.match_position);
                        errors++;
                    end
                    if (out_data.too_long !== head.too_long)
                    begin
                        $error("too_long: expected %0d, got %0d", head.too_long,
                               out_data.too_long);
                        errors++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up
            if (random_started && hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Stimulus
    initial
    begin
        pattern_bytes_t   pick;
        logic [7:0]       sym0;
        logic [7:0]       sym1;
        bit               narrow;
        logic [LEN_W-1:0] len;
        in_t              req;

        clear_text();

        // Empty pattern after reset: empty text, then bytes at both extremes
        add_req(8'h00, 1'b0, 1'b1, 1'b1, {1'b1, 16'd0, 1'b0});
        add_req(8'hFF, 1'b1, 1'b0);
        add_req(8'h00, 1'b1, 1'b1, 1'b1, {1'b1, 16'd0, 1'b0});
        // Pattern "abc": hit after a stray byte and a no-byte request
        add_write(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
        add_write(REG_PATTERN_LENGTH, 64'd3);
        add_req(8'h78, 1'b1, 1'b0);
        add_req(8'hA5, 1'b0, 1'b0);
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h62, 1'b1, 1'b0);
        add_req(8'h63, 1'b1, 1'b1, 1'b1, {1'b1, 16'd1, 1'b0});
        // Not found, closed by a no-byte request
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h62, 1'b1, 1'b0);
        add_req(8'h00, 1'b0, 1'b1, 1'b1, {1'b0, 16'd0, 1'b0});
        // Restarted partial match
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h62, 1'b1, 1'b0);
        add_req(8'h63, 1'b1, 1'b1);
        // Zero bytes are ordinary characters
        add_write(REG_PATTERN_LOW, 64'd0);
        add_write(REG_PATTERN_LENGTH, 64'd2);
        add_req(8'h01, 1'b1, 1'b0);
        add_req(8'h00, 1'b1, 1'b0);
        add_req(8'h00, 1'b1, 1'b1, 1'b1, {1'b1, 16'd1, 1'b0});
        // Length above the window size clamps to a full 16-byte pattern
        add_write(REG_PATTERN_LOW, '1);
        add_write(REG_PATTERN_HIGH, '1);
        add_write(REG_PATTERN_LENGTH, 64'd31);
        add_fill(PAT_BYTES - 1, 8'hFF);
        add_req(8'hFF, 1'b1, 1'b1, 1'b1, {1'b1, 16'd0, 1'b0});
        // Empty pattern again with a nonzero pattern register
        add_write(REG_PATTERN_LENGTH, 64'd0);
        add_req(8'hFF, 1'b1, 1'b1, 1'b1, {1'b1, 16'd0, 1'b0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WRITE:
                begin
                    settle();
                    write_reg(plan[i].index, plan[i].value);
                end
                ROW_REQ:
                    offer_request(plan[i].req, plan[i].known, plan[i].want);
                ROW_FILL:
                begin
                    steady        <= 1'b1;
                    req.text_byte = plan[i].value[7:0];
                    req.has_byte  = 1'b1;
                    req.last_item = 1'b0;
                    repeat (plan[i].count) offer_request(req, 1'b0, '0);
                    steady        <= 1'b0;
                end
                default: ;
            endcase
        end

        // Random phases: new pattern per phase, several texts each
        settle();
        random_started <= 1'b1;
        requests_sent  = 0;
        for (int phase = 0; requests_sent < RANDOM_ITEMS; phase++)
        begin
            settle();
            narrow = ($urandom_range(2) != 0);
            if ($urandom_range(2) == 0)
            begin
                sym0 = 8'h00;
                sym1 = 8'hFF;
            end
            else
            begin
                sym0 = 8'($urandom);
                sym1 = 8'($urandom);
            end
            for (int k = 0; k < PAT_BYTES; k++)
                pick[k] = narrow ? ($urandom_range(1) ? sym1 : sym0) : 8'($urandom);
            case ($urandom_range(5))
                0:       len = 5'd0;
                1:       len = 5'd1;
                2:       len = 5'd16;
                3:       len = LEN_W'($urandom_range(17, 31));
                default: len = LEN_W'($urandom_range(2, 15));
            endcase
            write_reg(REG_PATTERN_LOW, pick[7:0]);
            write_reg(REG_PATTERN_HIGH, pick[15:8]);
            write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
            steady <= (phase == 3);
            repeat ($urandom_range(4, 10)) send_text(sym0, sym1, narrow);
        end

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
